/* src/smv_pkg.sv */
// ----------------------------------------------------------------------------
// smv_pkg: shared types and constants
// Sizes, opcodes, register map, controller states and command/status groups
// for the sparse matrix-vector multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smv_pkg;

    localparam int VecDepth = 64;
    localparam int NnzDepth = 1024;
    localparam int PtrDepth = VecDepth + 1;
    localparam int VecAw    = $clog2(VecDepth);
    localparam int NnzAw    = $clog2(NnzDepth);
    localparam int PtrAw    = $clog2(PtrDepth);
    localparam int CntW     = $clog2(VecDepth + 1);
    localparam int PosW     = 11;
    localparam int DataW    = 32;
    localparam int IdxW     = 6;
    localparam int LenW     = 7;

    typedef enum logic [1:0] {
        OP_VEC  = 2'd0,
        OP_PTR  = 2'd1,
        OP_NZ   = 2'd2,
        OP_RUN  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_SEGS    = 2'd1,
        REG_OUTLEN  = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PTR0,
        ST_LO_WAIT,
        ST_SEG_RD,
        ST_SEG_WAIT,
        ST_NZ_CHECK,
        ST_VEC_RD,
        ST_MUL,
        ST_ACC,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    typedef struct packed {
        logic load_we;
        logic acc_clr;
        logic ptr_rd_first;
        logic ptr_rd_next;
        logic lo_load;
        logic hi_load;
        logic seg_adv;
        logic nz_rd;
        logic vec_rd;
        logic mul;
        logic acc_wr;
        logic out_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic k_lt_hi;
        logic seg_last;
        logic segs_zero;
        logic i_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* src/smv_ctrl.sv */
// ----------------------------------------------------------------------------
// smv_ctrl: run sequencer
// Walks segments, nonzeros and output elements, issuing datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_ctrl
    import smv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire opcode_t    in_op,
    input  wire status_t    status,
    output logic            in_ready,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_RUN)
                    begin
                        cmd.acc_clr = 1'b1;
                        state_next  = status.segs_zero ? ST_OUT_RD : ST_PTR0;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_PTR0:
            begin
                cmd.ptr_rd_first = 1'b1;
                state_next       = ST_LO_WAIT;
            end
            ST_LO_WAIT:
            begin
                cmd.lo_load = 1'b1;
                state_next  = ST_SEG_RD;
            end
            ST_SEG_RD:
            begin
                cmd.ptr_rd_next = 1'b1;
                state_next      = ST_SEG_WAIT;
            end
            ST_SEG_WAIT:
            begin
                cmd.hi_load = 1'b1;
                state_next  = ST_NZ_CHECK;
            end
            ST_NZ_CHECK:
            begin
                if (status.k_lt_hi)
                begin
                    cmd.nz_rd  = 1'b1;
                    state_next = ST_VEC_RD;
                end
                else
                begin
                    cmd.seg_adv = 1'b1;
                    state_next  = status.seg_last ? ST_OUT_RD : ST_SEG_RD;
                end
            end
            ST_VEC_RD:
            begin
                cmd.vec_rd = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_wr = 1'b1;
                state_next = ST_NZ_CHECK;
            end
            ST_OUT_RD:
            begin
                if (status.i_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.out_rd = 1'b1;
                    state_next = ST_OUT_LD;
                end
            end
            ST_OUT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_out_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> $past(cmd.out_rd))
        else $error("output load without read");
    a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_wr |-> $past(cmd.mul))
        else $error("accumulate without product");
`endif

endmodule

`default_nettype wire

/* src/smv_dp.sv */
// ----------------------------------------------------------------------------
// smv_dp: storage and multiply-accumulate datapath
// Holds vector, pointer, nonzero and accumulator memories, counters, the
// Q16.16 multiplier with saturating add, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_dp
    import smv_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    input  wire opcode_t             in_op,
    input  wire logic [PosW-1:0]     in_addr,
    input  wire logic [DataW-1:0]    in_value,
    input  wire logic [PosW-1:0]     in_position,
    input  wire logic                mode,
    input  wire logic [LenW-1:0]     segment_count,
    input  wire logic [LenW-1:0]     out_length,
    input  wire logic                out_ready,
    output status_t                  status,
    output logic                     out_valid,
    output logic [IdxW-1:0]          out_index,
    output logic [DataW-1:0]         out_value,
    output logic                     last
);

    logic [DataW-1:0] vec_mem [VecDepth];
    logic [PosW-1:0]  ptr_mem [PtrDepth];
    logic [DataW-1:0] nzv_mem [NnzDepth];
    logic [IdxW-1:0]  nzi_mem [NnzDepth];
    logic [DataW-1:0] acc_mem [VecDepth];
    logic [VecDepth-1:0] acc_vld_reg;

    logic [CntW-1:0]  s_reg;
    logic [CntW-1:0]  i_reg;
    logic [PosW-1:0]  k_reg;
    logic [PosW-1:0]  lo_reg;
    logic [PosW-1:0]  hi_reg;
    logic [PosW-1:0]  ptr_rd_reg;
    logic [DataW-1:0] nzv_rd_reg;
    logic [IdxW-1:0]  nzi_rd_reg;
    logic [DataW-1:0] vec_rd_reg;
    logic [DataW-1:0] acc_rd_reg;
    logic             acc_rdv_reg;
    logic signed [2*DataW-1:0] prod_reg;
    logic [VecAw-1:0] tgt_reg;
    logic             drop_reg;

    logic             out_valid_reg;
    logic [IdxW-1:0]  out_index_reg;
    logic [DataW-1:0] out_value_reg;
    logic             last_reg;

    logic [CntW-1:0]  segs;
    logic [CntW-1:0]  olen;
    logic [PosW-1:0]  hi_eff;
    logic [VecAw-1:0] tgt;
    logic [VecAw-1:0] acc_addr;
    logic [PtrAw-1:0] ptr_addr;
    logic [CntW-1:0]  s_inc;
    logic signed [2*DataW-17:0] psh;
    logic signed [2*DataW-16:0] sum;
    logic signed [DataW-1:0]    acc_cur;
    logic [DataW-1:0]           sat;

    always_comb
    begin
        segs   = (segment_count > LenW'(VecDepth)) ? CntW'(VecDepth) : CntW'(segment_count);
        olen   = mode ? ((out_length > LenW'(VecDepth)) ? CntW'(VecDepth) : CntW'(out_length))
                      : segs;
        hi_eff = (hi_reg > PosW'(NnzDepth)) ? PosW'(NnzDepth) : hi_reg;
        s_inc  = s_reg + CntW'(1);
        tgt    = mode ? nzi_rd_reg[VecAw-1:0] : s_reg[VecAw-1:0];
        acc_addr = cmd.out_rd ? i_reg[VecAw-1:0] : tgt;
        ptr_addr = cmd.ptr_rd_first ? '0 : PtrAw'(s_inc);
        acc_cur  = acc_rdv_reg ? $signed(acc_rd_reg) : '0;
        psh      = (2*DataW-16)'(prod_reg >>> 16);
        sum      = (2*DataW-15)'(acc_cur) + (2*DataW-15)'(psh);
        if (sum > (2*DataW-15)'(32'sh7fffffff))
        begin
            sat = 32'h7fffffff;
        end
        else if (sum < -(2*DataW-15)'(33'sh080000000))
        begin
            sat = 32'h80000000;
        end
        else
        begin
            sat = sum[DataW-1:0];
        end
        status.k_lt_hi   = k_reg < hi_eff;
        status.seg_last  = s_inc == segs;
        status.segs_zero = segs == '0;
        status.i_done    = i_reg == olen;
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            case (in_op)
                OP_VEC:
                begin
                    if (in_addr < PosW'(VecDepth))
                    begin
                        vec_mem[in_addr[VecAw-1:0]] <= in_value;
                    end
                end
                OP_PTR:
                begin
                    if (in_addr < PosW'(PtrDepth))
                    begin
                        ptr_mem[in_addr[PtrAw-1:0]] <= in_position;
                    end
                end
                OP_NZ:
                begin
                    if (in_addr < PosW'(NnzDepth))
                    begin
                        nzv_mem[in_addr[NnzAw-1:0]] <= in_value;
                        nzi_mem[in_addr[NnzAw-1:0]] <= in_position[IdxW-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.ptr_rd_first || cmd.ptr_rd_next)
        begin
            ptr_rd_reg <= ptr_mem[ptr_addr];
        end
        if (cmd.nz_rd)
        begin
            nzv_rd_reg <= nzv_mem[k_reg[NnzAw-1:0]];
            nzi_rd_reg <= nzi_mem[k_reg[NnzAw-1:0]];
        end
        if (cmd.vec_rd)
        begin
            vec_rd_reg <= vec_mem[mode ? s_reg[VecAw-1:0] : nzi_rd_reg[VecAw-1:0]];
        end
        if (cmd.mul || cmd.out_rd)
        begin
            acc_rd_reg  <= acc_mem[acc_addr];
            acc_rdv_reg <= acc_vld_reg[acc_addr];
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed(nzv_rd_reg) * $signed(vec_rd_reg);
            tgt_reg  <= tgt;
            drop_reg <= mode && (CntW'(nzi_rd_reg) >= olen);
        end
        if (cmd.acc_wr && !drop_reg)
        begin
            acc_mem[tgt_reg] <= sat;
        end
        if (cmd.out_load)
        begin
            out_index_reg <= i_reg[IdxW-1:0];
            out_value_reg <= acc_rdv_reg ? acc_rd_reg : '0;
            last_reg      <= (i_reg + CntW'(1)) == olen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            s_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
        end
        else
        begin
            if (cmd.acc_clr)
            begin
                acc_vld_reg <= '0;
                s_reg       <= '0;
                i_reg       <= '0;
            end
            if (cmd.lo_load)
            begin
                lo_reg <= ptr_rd_reg;
            end
            if (cmd.hi_load)
            begin
                hi_reg <= ptr_rd_reg;
                k_reg  <= lo_reg;
            end
            if (cmd.seg_adv)
            begin
                lo_reg <= hi_reg;
                s_reg  <= s_inc;
            end
            if (cmd.acc_wr)
            begin
                k_reg <= k_reg + PosW'(1);
                if (!drop_reg)
                begin
                    acc_vld_reg[tgt_reg] <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                i_reg         <= i_reg + CntW'(1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten");
    a_gather_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc_wr && !mode) |-> !drop_reg)
        else $error("gather product dropped");
    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nz_rd |-> (k_reg < PosW'(NnzDepth)))
        else $error("nonzero read out of range");
`endif

endmodule

`default_nettype wire

/* src/sparse_matrix_vector_multiply_unit.sv */
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_unit: CSR/CSC sparse matrix-vector multiply
// Loads a compressed sparse matrix and a dense vector, then on a run
// computes the product in gather or scatter mode, Q16.16 saturating.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   opcode, addr, value, position
//   out      output     out_valid / out_ready out_index, out_value, last
//   cfg      input      APB write/read        mode, segment_count, out_length
//
// Load transactions are accepted only while the sequencer is idle. A run
// walks the segment pointers, steps each nonzero through the dependent
// nonzero, vector and accumulator reads and its accumulate, then reads out
// each output element.
// Reset clears control state only; stores hold garbage until written.
// Output stalls hold the sequencer in its output phase.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matrix_vector_multiply_unit
    import smv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        opcode,
    input  wire logic [PosW-1:0]   addr,
    input  wire logic [DataW-1:0]  value,
    input  wire logic [PosW-1:0]   position,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [IdxW-1:0]        out_index,
    output logic [DataW-1:0]       out_value,
    output logic                   last
);

    logic            mode_reg;
    logic [LenW-1:0] segs_reg;
    logic [LenW-1:0] olen_reg;
    reg_index_t      reg_sel;
    opcode_t         in_op;
    cmd_t            cmd;
    status_t         status;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign in_op   = opcode_t'(opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            segs_reg <= LenW'(VecDepth);
            olen_reg <= LenW'(VecDepth);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_MODE:   mode_reg <= pwdata[0];
                REG_SEGS:   segs_reg <= pwdata[LenW-1:0];
                REG_OUTLEN: olen_reg <= pwdata[LenW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_MODE:   prdata = {31'd0, mode_reg};
            REG_SEGS:   prdata = {25'd0, segs_reg};
            REG_OUTLEN: prdata = {25'd0, olen_reg};
            default:    prdata = '0;
        endcase
    end

    smv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_op),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    smv_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_op         (in_op),
        .in_addr       (addr),
        .in_value      (value),
        .in_position   (position),
        .mode          (mode_reg),
        .segment_count (segs_reg),
        .out_length    (olen_reg),
        .out_ready     (out_ready),
        .status        (status),
        .out_valid     (out_valid),
        .out_index     (out_index),
        .out_value     (out_value),
        .last          (last)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the sparse matrix-vector multiply unit
// Loads vectors, segment pointers and nonzeros over the input channel,
// programs mode and lengths over the register port, issues run commands and
// checks every output element against an in-bench fixed-point predictor.
// Both channels see random idle gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import smv_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int RunSettle  = 4400;
    localparam int RandItems  = 460;

    typedef struct {
        logic [IdxW-1:0]  idx;
        logic [DataW-1:0] val;
        logic             fin;
    } elem_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        opcode;
    logic [PosW-1:0]   addr;
    logic [DataW-1:0]  value;
    logic [PosW-1:0]   position;
    logic              out_valid;
    logic              out_ready;
    logic [IdxW-1:0]   out_index;
    logic [DataW-1:0]  out_value;
    logic              last;

    logic [DataW-1:0]  vec_m [VecDepth];
    logic [PosW-1:0]   ptr_m [PtrDepth];
    logic [DataW-1:0]  nzv_m [NnzDepth];
    logic [IdxW-1:0]   nzi_m [NnzDepth];
    logic              mode_m;
    logic [LenW-1:0]   segs_m;
    logic [LenW-1:0]   olen_m;

    elem_t             pending_elems[$];
    int                errors;
    int                cycles;
    int                items_sent;
    bit                quiet;
    int                stall_left;

    sparse_matrix_vector_multiply_unit dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic logic [DataW-1:0] rand_q();
        logic [DataW-1:0] v;
        if ($urandom_range(0, 9) < 3)
            return $urandom;
        v = $urandom_range(0, 32'h3FFFF);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic void predict_products();
        logic signed [63:0] acc [VecDepth];
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        int segs;
        int olen;
        int lo;
        int hi;
        logic [DataW-1:0] x;
        elem_t e;
        segs = (segs_m > VecDepth) ? VecDepth : segs_m;
        olen = !mode_m ? segs : ((olen_m > VecDepth) ? VecDepth : olen_m);
        foreach (acc[i])
            acc[i] = 0;
        for (int s = 0; s < segs; s++)
        begin
            lo = ptr_m[s];
            hi = ptr_m[s + 1];
            if (hi > NnzDepth)
                hi = NnzDepth;
            for (int k = lo; k < hi; k++)
            begin
                if (mode_m && nzi_m[k] >= olen)
                    continue;
                x = mode_m ? vec_m[s] : vec_m[nzi_m[k]];
                prod = ($signed({{32{nzv_m[k][31]}}, nzv_m[k]}) *
                        $signed({{32{x[31]}}, x})) >>> 16;
                sum = acc[mode_m ? int'(nzi_m[k]) : s] + prod;
                if (sum > 64'sd2147483647)
                    sum = 64'sd2147483647;
                if (sum < -64'sd2147483648)
                    sum = -64'sd2147483648;
                acc[mode_m ? int'(nzi_m[k]) : s] = sum;
            end
        end
        for (int i = 0; i < olen; i++)
        begin
            e.idx = IdxW'(i);
            e.val = acc[i][31:0];
            e.fin = (i == olen - 1);
            pending_elems.push_back(e);
        end
    endfunction

    function automatic void apply_item(input opcode_t op, input int a,
                                       input logic [DataW-1:0] v,
                                       input logic [PosW-1:0] p);
        case (op)
            OP_VEC: if (a < VecDepth) vec_m[a] = v;
            OP_PTR: if (a < PtrDepth) ptr_m[a] = p;
            OP_NZ:
                if (a < NnzDepth)
                begin
                    nzv_m[a] = v;
                    nzi_m[a] = p[IdxW-1:0];
                end
            OP_RUN: predict_products();
        endcase
    endfunction

    task automatic send_item(input opcode_t op, input int a,
                             input logic [DataW-1:0] v, input int p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        addr     <= PosW'(a);
        value    <= v;
        position <= PosW'(p);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_item(op, a, v, PosW'(p));
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_elems.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t r, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (r)
            REG_MODE:   mode_m = d[0];
            REG_SEGS:   segs_m = d[LenW-1:0];
            REG_OUTLEN: olen_m = d[LenW-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int m, input int segs, input int olen);
        wait_drained();
        repeat (RunSettle) @(posedge clk);
        write_reg(REG_MODE, m);
        write_reg(REG_SEGS, segs);
        write_reg(REG_OUTLEN, olen);
        @(posedge clk);
    endtask

    // rewrite every pointer a run can read, the nonzeros they cover, then run
    task automatic load_matrix_and_run(input int max_step);
        int n;
        int p;
        int top;
        int q;
        n = (segs_m > VecDepth) ? VecDepth : segs_m;
        p = 0;
        top = 0;
        for (int s = 0; s <= n; s++)
        begin
            q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, p) : p;
            send_item(OP_PTR, s, rand_q(), q);
            if (q > top)
                top = q;
            p += $urandom_range(0, max_step);
        end
        for (int k = 0; k < top; k++)
            send_item(OP_NZ, k, rand_q(), $urandom_range(0, 2047));
        repeat ($urandom_range(0, 4))
            send_item(OP_VEC, $urandom_range(0, VecDepth - 1), rand_q(), $urandom);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 2))
                0: send_item(OP_VEC, $urandom_range(VecDepth, 2047), $urandom, $urandom);
                1: send_item(OP_PTR, $urandom_range(n + 1, 2047), $urandom, $urandom);
                default: send_item(OP_NZ, $urandom_range(0, 2047), $urandom, $urandom);
            endcase
        end
        send_item(OP_RUN, $urandom_range(0, 2047), $urandom, $urandom);
    endtask

    always @(posedge clk)
    begin
        elem_t e;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_elems.size() == 0)
                    report($sformatf("unexpected element %0d", out_index));
                else
                begin
                    e = pending_elems.pop_front();
                    if (out_index !== e.idx)
                        report($sformatf("index %0d, want %0d", out_index, e.idx));
                    if (out_value !== e.val)
                        report($sformatf("element %0d value %h, want %h",
                                         e.idx, out_value, e.val));
                    if (last !== e.fin)
                        report($sformatf("element %0d last %b, want %b",
                                         e.idx, last, e.fin));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                stall_left <= pick_gap();
                out_ready  <= 1'b1;
            end
        end
    end

    task automatic test_load_stores();
        for (int i = 0; i < VecDepth; i++)
            send_item(OP_VEC, i, rand_q(), 0);
        for (int i = 0; i < PtrDepth; i++)
            send_item(OP_PTR, i, 0, 0);
    endtask

    task automatic test_directed_edges();
        set_config(0, 3, 5);
        send_item(OP_VEC, 0, 32'h7FFF_FFFF, 0);
        send_item(OP_VEC, 63, 32'h8000_0000, 0);
        send_item(OP_VEC, 1, 32'h0001_0000, 0);
        send_item(OP_VEC, 64, 32'hFFFF_FFFF, 0);
        send_item(OP_VEC, 2047, 32'h1234_5678, 0);
        send_item(OP_PTR, 0, 0, 0);
        send_item(OP_PTR, 1, 0, 2);
        send_item(OP_PTR, 2, 0, 1);
        send_item(OP_PTR, 3, 0, 6);
        send_item(OP_PTR, 65, 0, 2047);
        send_item(OP_NZ, 0, 32'h7FFF_FFFF, 0);
        send_item(OP_NZ, 1, 32'h7FFF_FFFF, 0);
        send_item(OP_NZ, 2, 32'h8000_0000, 2047);
        send_item(OP_NZ, 3, 32'h7FFF_FFFF, 63);
        send_item(OP_NZ, 4, 32'hFFFF_FFFF, 1);
        send_item(OP_NZ, 5, 32'h0000_0001, 1024 + 1);
        send_item(OP_NZ, 1024, 32'h5555_5555, 3);
        send_item(OP_NZ, 2047, 32'hAAAA_AAAA, 2046);
        send_item(OP_RUN, 0, 0, 0);
        // hold the sender until the whole run has drained
        wait_drained();
        send_item(OP_RUN, 2047, 32'hFFFF_FFFF, 2047);
        set_config(1, 3, 5);
        send_item(OP_RUN, 0, 0, 0);
    endtask

    task automatic test_pointer_clamp();
        set_config(0, 1, 1);
        send_item(OP_PTR, 0, 0, 1020);
        send_item(OP_PTR, 1, 0, 2047);
        for (int k = 1020; k < NnzDepth; k++)
            send_item(OP_NZ, k, rand_q(), $urandom_range(0, 63));
        send_item(OP_RUN, 0, 0, 0);
        set_config(1, 1, 64);
        send_item(OP_RUN, 0, 0, 0);
    endtask

    task automatic test_count_extremes();
        set_config(0, 0, 64);
        load_matrix_and_run(2);
        set_config(1, 64, 0);
        load_matrix_and_run(0);
        set_config(0, 127, 0);
        load_matrix_and_run(1);
        set_config(1, 1, 127);
        load_matrix_and_run(3);
        set_config(1, 127, 1);
        load_matrix_and_run(1);
    endtask

    task automatic test_random_runs();
        int segs;
        do
        begin
            quiet = ($urandom_range(0, 5) == 0);
            segs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(1, 8);
            set_config($urandom_range(0, 1), segs, $urandom_range(0, 127) >>
                       ($urandom_range(0, 1) ? 0 : 3));
            repeat ($urandom_range(1, 3))
                load_matrix_and_run(segs > 16 ? 1 : 4);
        end
        while (items_sent < RandItems);
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        opcode = '0;
        addr = '0;
        value = '0;
        position = '0;
        out_ready = 1'b0;
        stall_left = 0;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        quiet = 1'b0;
        mode_m = 1'b0;
        segs_m = 7'd64;
        olen_m = 7'd64;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_stores();
        test_directed_edges();
        test_pointer_clamp();
        test_count_extremes();
        test_random_runs();

        wait_drained();
        repeat (RunSettle) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
